// ----- sv/cehist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cehist_pkg
// Shared types and constants of the cylindrical energy histogram: field
// widths, command and result codes, register indexes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cehist_pkg;

   // field widths
   localparam int POS_W     = 20;  // magnitude bits of a position / radius / depth
   localparam int CFG_W     = 20;  // widest configuration register
   localparam int BINS_W    = 7;
   localparam int CMD_W     = 2;
   localparam int SEL_W     = 12;
   localparam int EN_W      = 32;
   localparam int VAL_W     = 48;
   localparam int EVT_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [EVT_W-1:0] EVT_MAX = '1;

   // floor(x/5) as (x * ZB_MUL) >> ZB_SHIFT, exact for x < 2^21
   localparam logic [21:0] ZB_MUL   = 22'd3355444;
   localparam int          ZB_SHIFT = 24;
   // floor(x/5) as (x * ND_MUL) >> ND_SHIFT, exact for x < 1024
   localparam int          ND_MUL   = 205;
   localparam int          ND_SHIFT = 10;

   // register reset values
   localparam logic [CFG_W-1:0]  RADIUS_RST = 20'd10240;
   localparam logic [CFG_W-1:0]  DEPTH_RST  = 20'd20480;
   localparam logic [BINS_W-1:0] BINS_RST   = 7'd32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_BINS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_BINS = 2'd3;

   // result codes
   localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADBIN = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_DEPOSIT = 2'd0,
      CMD_READ    = 2'd1,
      CMD_MERGE   = 2'd2,
      CMD_EVENTS  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCALE,
      ST_RSTART,
      ST_RWAIT,
      ST_ZSET,
      ST_ZSTART,
      ST_ZWAIT,
      ST_FLAT,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;      // write zero at the sweep address, advance it
      logic load;       // capture the request
      logic square;     // square position and radius, load bin index
      logic load_r;     // load divider operands for the radius bin
      logic load_z;     // keep radius bin, load operands for the depth bin
      logic div_start;  // launch the divider
      logic make_flat;  // form the flat bin index
      logic ram_read;   // read the selected bin
      logic update;     // saturating add, write back
      logic out_load;   // fill the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type code;
      logic   pos_ok;
      logic   sel_ok;
      logic   div_done;
      logic   clear_last;
      logic   out_free;
   } status_type;

endpackage

// ----- sv/cylindrical_energy_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical_energy_histogram
// Radius-by-depth energy histogram. Deposits are binned (sqrt-spaced radius,
// two-zone depth) and summed with saturation; bins can be read or merged into,
// and an event counter can be advanced.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   command, r_pos, z_pos, energy,
//                                                 bin_select, merge_value
//   rsp_      out         rsp_valid / rsp_stall   status, bin_hit, bin_sum, events
//   csr_      in          csr_write               csr_index, csr_data
//
// Transaction steps, accept to next accept, with QW the divider width
// (max of clog2(MAX_R_BINS+1), clog2(MAX_Z_BINS+1), 7 by default):
//   deposit in range: two passes of the one-bit-a-cycle divider, QW bits each,
//   plus the read-modify-write of the bin RAM; read / merge: the bin
//   read-modify-write; add events, rejected deposit or bad bin index: neither.
// Reset: a clearing sweep writes zero to all MAX_R_BINS*MAX_Z_BINS bins with
//   req_stall high; configuration writes are taken.
// Stalls: the result sits in an output register; the next transaction is
//   accepted while it waits, and only its own result load waits on rsp_stall.
// ----------------------------------------------------------------------------
module cylindrical_energy_histogram import cehist_pkg::*; #(
   parameter int MAX_R_BINS = 64,
   parameter int MAX_Z_BINS = 64,
   parameter int SUM_WIDTH  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic signed [POS_W:0] req_r_pos,
   input  logic signed [POS_W:0] req_z_pos,
   input  logic [EN_W-1:0]       req_energy,
   input  logic [SEL_W-1:0]      req_bin_select,
   input  logic [VAL_W-1:0]      req_merge_value,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [SEL_W-1:0]      rsp_bin_hit,
   output logic [VAL_W-1:0]      rsp_bin_sum,
   output logic [EVT_W-1:0]      rsp_events,
   // configuration write port
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   // command and status bundles between sequencer and datapath
   cmd_type    cmd;
   status_type st;

   // sequencer: owns the request handshake and steps each transaction
   cehist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .st        (st),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // datapath: configuration, bin arithmetic, bin store, result register
   cehist_dp #(
      .MAX_R_BINS (MAX_R_BINS),
      .MAX_Z_BINS (MAX_Z_BINS),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_command     (req_command),
      .req_r_pos       (req_r_pos),
      .req_z_pos       (req_z_pos),
      .req_energy      (req_energy),
      .req_bin_select  (req_bin_select),
      .req_merge_value (req_merge_value),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_bin_hit     (rsp_bin_hit),
      .rsp_bin_sum     (rsp_bin_sum),
      .rsp_events      (rsp_events)
   );

endmodule

// ----- sv/cehist_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cehist_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cehist_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cehist_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cehist_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QW bits, so the high dividend bits start as remainder.
// ----------------------------------------------------------------------------
module cehist_div import cehist_pkg::*; #(
   parameter int DW = 47,
   parameter int VW = 40,
   parameter int QW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [VW-1:0] den,
   output logic [QW-1:0] quo,
   output logic          done
);

   localparam int CW = $clog2(QW + 1);

   logic [VW-1:0] rem_ff, den_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;

   logic [VW:0]   trial, diff;
   logic          ge;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= VW'(num >> QW);
         quo_ff <= num[QW-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? VW'(diff) : VW'(trial);
         quo_ff <= QW'({quo_ff, ge});
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

`ifndef SYNTH
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule

// ----- sv/cehist_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cehist_dp
// Histogram datapath: configuration registers, request capture, bin index
// arithmetic, the bin store with its clearing sweep, and the result register.
// ----------------------------------------------------------------------------
module cehist_dp import cehist_pkg::*; #(
   parameter int MAX_R_BINS = 64,
   parameter int MAX_Z_BINS = 64,
   parameter int SUM_WIDTH  = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  st,
   input  logic [CMD_W-1:0]            req_command,
   input  logic signed [POS_W:0]       req_r_pos,
   input  logic signed [POS_W:0]       req_z_pos,
   input  logic [EN_W-1:0]             req_energy,
   input  logic [SEL_W-1:0]            req_bin_select,
   input  logic [VAL_W-1:0]            req_merge_value,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STAT_W-1:0]           rsp_status,
   output logic [SEL_W-1:0]            rsp_bin_hit,
   output logic [VAL_W-1:0]            rsp_bin_sum,
   output logic [EVT_W-1:0]            rsp_events
);

   localparam int NRW   = $clog2(MAX_R_BINS + 1);
   localparam int NZW   = $clog2(MAX_Z_BINS + 1);
   localparam int QW    = (NRW > NZW) ? NRW : NZW;
   localparam int VW    = 2 * POS_W;
   localparam int DW_R  = NRW + VW;
   localparam int DW_Z  = NZW + POS_W;
   localparam int DW    = (DW_R > DW_Z) ? DW_R : DW_Z;
   localparam int STORE = MAX_R_BINS * MAX_Z_BINS;
   localparam int AW    = $clog2(STORE);
   localparam int XW    = (SUM_WIDTH > VAL_W) ? SUM_WIDTH : VAL_W;
   localparam int PW    = NRW + NZW;
   localparam int ZBW   = POS_W + 24;
   localparam int NDW   = NZW + ND_SHIFT;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

   // configuration
   logic [CFG_W-1:0]  radius_ff, depth_ff;
   logic [BINS_W-1:0] r_bins_ff, z_bins_ff;
   logic [POS_W-1:0]  zbreak_ff;
   logic [NZW-1:0]    ndense_ff;

   // captured request
   op_type            op_ff;
   logic [POS_W:0]    rp_ff, zp_ff;
   logic [EN_W-1:0]   energy_ff;
   logic [SEL_W-1:0]  sel_ff;
   logic [VAL_W-1:0]  mv_ff;

   // working registers
   logic [VW-1:0]     rsq_ff, radsq_ff, den_ff;
   logic [DW-1:0]     num_ff;
   logic [NRW-1:0]    ir_ff;
   logic              zlow_ff;
   logic [AW-1:0]     flat_ff, clr_ff;
   logic [SUM_WIDTH-1:0] sum_ff;

   // result register
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [SEL_W-1:0]  rsp_hit_ff;
   logic [VAL_W-1:0]  rsp_sum_ff;
   logic [EVT_W-1:0]  rsp_events_ff;
   logic [EVT_W-1:0]  events_ff;

   logic [NRW-1:0]    nr;
   logic [NZW-1:0]    nz, iz;
   logic [PW-1:0]     bins_prod;
   logic [ZBW-1:0]    zb_prod;
   logic [NDW-1:0]    nd_prod;
   logic              pos_ok, sel_ok, zlow, out_free;
   logic [QW-1:0]     quo;
   logic              div_done;
   logic [SUM_WIDTH-1:0] rd_data, addend, sum_new;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [XW-1:0]        mv_x;
   logic [VAL_W:0]       ev_sum;
   logic [EVT_W-1:0]     ev_sat;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [SUM_WIDTH-1:0] ram_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         depth_ff  <= DEPTH_RST;
         r_bins_ff <= BINS_RST;
         z_bins_ff <= BINS_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_DEPTH:  depth_ff  <= csr_data;
            CSR_R_BINS: r_bins_ff <= csr_data[BINS_W-1:0];
            CSR_Z_BINS: z_bins_ff <= csr_data[BINS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp bin counts to the store geometry, with at least 1 radius and 2 depth bins
   always_comb begin
      if (r_bins_ff == '0) begin
         nr = NRW'(1);
      end else if (32'(r_bins_ff) > MAX_R_BINS) begin
         nr = NRW'(MAX_R_BINS);
      end else begin
         nr = NRW'(r_bins_ff);
      end
      if (32'(z_bins_ff) < 2) begin
         nz = NZW'(2);
      end else if (32'(z_bins_ff) > MAX_Z_BINS) begin
         nz = NZW'(MAX_Z_BINS);
      end else begin
         nz = NZW'(z_bins_ff);
      end
   end

   // depth break point 2*depth/5 and dense bin count 3*nz/5
   assign zb_prod = ZBW'({depth_ff, 1'b0}) * ZBW'(ZB_MUL);
   assign nd_prod = NDW'(nz) * NDW'(3 * ND_MUL);

   always_ff @(posedge clock) begin
      zbreak_ff <= zb_prod[ZB_SHIFT +: POS_W];
      ndense_ff <= nd_prod[ND_SHIFT +: NZW];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_command);
         rp_ff     <= req_r_pos;
         zp_ff     <= req_z_pos;
         energy_ff <= req_energy;
         sel_ff    <= req_bin_select;
         mv_ff     <= req_merge_value;
      end
   end

   assign pos_ok = !rp_ff[POS_W] && !zp_ff[POS_W]
                   && (rp_ff[POS_W-1:0] < radius_ff) && (zp_ff[POS_W-1:0] < depth_ff);
   assign bins_prod = PW'(nr) * PW'(nz);
   assign sel_ok = (32'(sel_ff) < 32'(bins_prod)) && (32'(sel_ff) < STORE);
   assign zlow   = zp_ff[POS_W-1:0] < zbreak_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         rsq_ff   <= VW'(rp_ff[POS_W-1:0]) * VW'(rp_ff[POS_W-1:0]);
         radsq_ff <= VW'(radius_ff) * VW'(radius_ff);
         flat_ff  <= AW'(sel_ff);
      end
      if (cmd.load_r) begin
         num_ff <= DW'(nr) * DW'(rsq_ff);
         den_ff <= radsq_ff;
      end
      if (cmd.load_z) begin
         ir_ff   <= NRW'(quo);
         zlow_ff <= zlow;
         if (zlow) begin
            num_ff <= DW'(ndense_ff) * DW'(zp_ff[POS_W-1:0]);
            den_ff <= VW'(zbreak_ff);
         end else begin
            num_ff <= DW'(nz - ndense_ff) * DW'(zp_ff[POS_W-1:0] - zbreak_ff);
            den_ff <= VW'(depth_ff - zbreak_ff);
         end
      end
      if (cmd.make_flat) begin
         flat_ff <= AW'(ir_ff) * AW'(nz) + AW'(iz);
      end
      if (cmd.update) begin
         sum_ff <= sum_new;
      end
   end

   assign iz = zlow_ff ? NZW'(quo) : ndense_ff + NZW'(quo);

   cehist_div #(
      .DW (DW),
      .VW (VW),
      .QW (QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .quo   (quo),
      .done  (div_done)
   );

   // saturating bin update
   assign mv_x = XW'(mv_ff);
   always_comb begin
      case (op_ff)
         CMD_DEPOSIT: addend = SUM_WIDTH'(energy_ff);
         CMD_MERGE:   addend = (mv_x > XW'(SUM_MAX)) ? SUM_MAX : SUM_WIDTH'(mv_x);
         default:     addend = '0;
      endcase
   end
   assign sum_wide = {1'b0, rd_data} + {1'b0, addend};
   assign sum_new  = sum_wide[SUM_WIDTH] ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];

   // clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign ram_we    = cmd.clear || (cmd.update && (op_ff != CMD_READ));
   assign ram_waddr = cmd.clear ? clr_ff : flat_ff;
   assign ram_wdata = cmd.clear ? '0 : sum_new;

   cehist_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (STORE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.ram_read),
      .rd_addr (flat_ff),
      .rd_data (rd_data)
   );

   // event count and result register
   assign ev_sum = (VAL_W + 1)'(events_ff) + (VAL_W + 1)'(mv_ff);
   assign ev_sat = (ev_sum > (VAL_W + 1)'(EVT_MAX)) ? EVT_MAX : EVT_W'(ev_sum);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         events_ff    <= '0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.out_load && (op_ff == CMD_EVENTS)) begin
            events_ff <= ev_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_events_ff <= (op_ff == CMD_EVENTS) ? ev_sat : events_ff;
         rsp_status_ff <= STAT_DONE;
         rsp_hit_ff    <= '0;
         rsp_sum_ff    <= '0;
         case (op_ff)
            CMD_DEPOSIT: begin
               if (pos_ok) begin
                  rsp_hit_ff <= SEL_W'(flat_ff);
                  rsp_sum_ff <= VAL_W'(sum_ff);
               end else begin
                  rsp_status_ff <= STAT_RANGE;
               end
            end
            CMD_READ, CMD_MERGE: begin
               if (sel_ok) begin
                  rsp_hit_ff <= SEL_W'(flat_ff);
                  rsp_sum_ff <= VAL_W'(sum_ff);
               end else begin
                  rsp_status_ff <= STAT_BADBIN;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_bin_hit = rsp_hit_ff;
   assign rsp_bin_sum = rsp_sum_ff;
   assign rsp_events  = rsp_events_ff;

   assign st.code       = op_ff;
   assign st.pos_ok     = pos_ok;
   assign st.sel_ok     = sel_ok;
   assign st.div_done   = div_done;
   assign st.clear_last = (clr_ff == AW'(STORE - 1));
   assign st.out_free   = out_free;

`ifndef SYNTH
   a_flat_in_grid : assert property (@(posedge clock) disable iff (reset)
      $past(cmd.make_flat) |-> (32'(flat_ff) < 32'(bins_prod)))
      else $error("flat bin index outside the active grid");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten before it was taken");
`endif

endmodule

// ----- sv/cehist_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cehist_ctrl
// Sequencer of the histogram: clearing sweep after reset, then one request at
// a time through decode, two divisions, read-modify-write and result load.
// ----------------------------------------------------------------------------
module cehist_ctrl import cehist_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type st,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (st.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (st.code)
               CMD_DEPOSIT:         state_in = st.pos_ok ? ST_SCALE : ST_FINISH;
               CMD_READ, CMD_MERGE: state_in = st.sel_ok ? ST_READ : ST_FINISH;
               default:             state_in = ST_FINISH;
            endcase
         end
         ST_SCALE:  state_in = ST_RSTART;
         ST_RSTART: state_in = ST_RWAIT;
         ST_RWAIT:  if (st.div_done) state_in = ST_ZSET;
         ST_ZSET:   state_in = ST_ZSTART;
         ST_ZSTART: state_in = ST_ZWAIT;
         ST_ZWAIT:  if (st.div_done) state_in = ST_FLAT;
         ST_FLAT:   state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: if (st.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR:  cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DECODE: cmd.square    = 1'b1;
         ST_SCALE:  cmd.load_r    = 1'b1;
         ST_RSTART: cmd.div_start = 1'b1;
         ST_ZSET:   cmd.load_z    = 1'b1;
         ST_ZSTART: cmd.div_start = 1'b1;
         ST_FLAT:   cmd.make_flat = 1'b1;
         ST_READ:   cmd.ram_read  = 1'b1;
         ST_UPDATE: cmd.update    = 1'b1;
         ST_FINISH: cmd.out_load  = st.out_free;
         default: ;
      endcase
   end

`ifndef SYNTH
   a_update_after_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> ($past(state_ff) == ST_READ))
      else $error("bin update without a preceding read");
`endif

endmodule
